@@ hw/rtl/tvf_pkg.sv @@
// ============================================================================
// tvf_pkg
// Shared types, constants and the fade step table of the track fade engine.
// ============================================================================
package tvf_pkg;

    localparam int NUM_TRACKS = 16;
    localparam int IDX_W      = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    // operation codes
    localparam logic [2:0] FN_LOAD = 3'd0;
    localparam logic [2:0] FN_FADE = 3'd1;
    localparam logic [2:0] FN_STOP = 3'd2;
    localparam logic [2:0] FN_TICK = 3'd3;
    localparam logic [2:0] FN_POLL = 3'd4;

    localparam logic [22:0] LEVEL_MASK  = 23'h7f0000;
    localparam logic [31:0] LEVEL_EVENT = 32'ha01c0000;
    localparam logic [31:0] STOP_EVENT  = 32'ha0001200;
    localparam logic [7:0]  RUN_MASK    = 8'h21;
    localparam logic [7:0]  FADE_FLAGS  = 8'h06;
    localparam logic [7:0]  HDR_PROT    = 8'h80;
    localparam logic [7:0]  HDR_LOCAL   = 8'h40;
    localparam logic [7:0]  HDR_EXT     = 8'h20;

    localparam logic [15:0] STEP_TABLE [128] = '{
        16'd41943, 16'd27962, 16'd20971, 16'd16777, 16'd13981, 16'd11983, 16'd10485, 16'd9320,
        16'd8388,  16'd7626,  16'd6990,  16'd6452,  16'd5991,  16'd5592,  16'd5242,  16'd4934,
        16'd4660,  16'd4415,  16'd4194,  16'd3994,  16'd3813,  16'd3647,  16'd3495,  16'd3355,
        16'd3226,  16'd3106,  16'd2995,  16'd2892,  16'd2796,  16'd2706,  16'd2621,  16'd2542,
        16'd2467,  16'd2396,  16'd2330,  16'd2267,  16'd2207,  16'd2150,  16'd2097,  16'd2046,
        16'd1997,  16'd1950,  16'd1906,  16'd1864,  16'd1823,  16'd1784,  16'd1747,  16'd1711,
        16'd1677,  16'd1644,  16'd1613,  16'd1582,  16'd1553,  16'd1525,  16'd1497,  16'd1471,
        16'd1446,  16'd1421,  16'd1398,  16'd1375,  16'd1353,  16'd1331,  16'd1310,  16'd1290,
        16'd1271,  16'd1252,  16'd1233,  16'd1215,  16'd1198,  16'd1181,  16'd1165,  16'd1149,
        16'd1133,  16'd1118,  16'd1103,  16'd1089,  16'd1075,  16'd1061,  16'd1048,  16'd1035,
        16'd1023,  16'd1010,  16'd998,   16'd986,   16'd975,   16'd964,   16'd953,   16'd942,
        16'd932,   16'd921,   16'd911,   16'd902,   16'd892,   16'd883,   16'd873,   16'd864,
        16'd855,   16'd847,   16'd838,   16'd830,   16'd822,   16'd814,   16'd806,   16'd798,
        16'd791,   16'd783,   16'd776,   16'd769,   16'd762,   16'd755,   16'd748,   16'd742,
        16'd735,   16'd729,   16'd723,   16'd716,   16'd710,   16'd704,   16'd699,   16'd693,
        16'd687,   16'd682,   16'd676,   16'd671,   16'd665,   16'd660,   16'd655,   16'd650
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_EMIT2
    } state_t;

    typedef struct packed {
        logic [7:0]  flags;
        logic [7:0]  header;
        logic [7:0]  bank;
        logic [22:0] volume;
        logic [16:0] step;
        logic [22:0] reported;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // fields of one request held for the duration of its work
    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  bank;
        logic [6:0]  rate;
        logic [7:0]  flags;
        logic [7:0]  header;
        logic [22:0] volume;
        logic [22:0] last_level;
    } req_t;

    typedef struct packed {
        logic        event_valid;
        logic [31:0] event_word;
        logic        to_local;
        logic        to_external;
        logic        stop_group;
        logic        found;
        logic        last;
    } res_t;

    // outcome of applying one request to one entry
    typedef struct packed {
        logic   wr;
        entry_t ent;
        logic   hit;
        logic   has1;
        logic   has2;
        res_t   res1;
        res_t   res2;
    } upd_t;

endpackage

@@ hw/rtl/tvf_ram.sv @@
// ============================================================================
// tvf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module tvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/tvf_update.sv @@
// ============================================================================
// tvf_update
// Modify stage: applies one request to one track entry read from the table.
// ============================================================================
module tvf_update import tvf_pkg::*; (
    input  req_t   req,
    input  entry_t cur,
    output upd_t   upd
);

    logic               running;
    logic               fade_hit;
    logic               stop_hit;
    logic signed [24:0] sum;
    logic [22:0]        tick_vol;
    logic [22:0]        level;
    logic               lvl_new;
    logic               loc;
    logic               ext;
    logic               lvl_zero;
    logic [16:0]        fade_step;

    assign running   = ((cur.flags & RUN_MASK) == 8'h00) && cur.flags[1];
    assign fade_hit  = (cur.flags != 8'h00) && ((cur.header & HDR_PROT) == 8'h00)
                       && (cur.bank == req.bank);
    assign stop_hit  = !req.bank[7] && (cur.bank == {5'b0, req.bank[2:0]})
                       && ((cur.header & HDR_PROT) == 8'h00);
    assign fade_step = 17'd0 - {1'b0, STEP_TABLE[req.rate]};

    // clamp the ramp to the level range
    assign sum = $signed({2'b00, cur.volume}) + $signed({{8{cur.step[16]}}, cur.step});
    always_comb
    begin
        if (sum[24])
        begin
            tick_vol = 23'd0;
        end
        else if (sum[23:0] > {1'b0, LEVEL_MASK})
        begin
            tick_vol = LEVEL_MASK;
        end
        else
        begin
            tick_vol = sum[22:0];
        end
    end

    assign level    = cur.volume & LEVEL_MASK;
    assign lvl_new  = running && (level != cur.reported);
    assign loc      = (cur.header & HDR_LOCAL) != 8'h00;
    assign ext      = (cur.header & HDR_EXT) != 8'h00;
    assign lvl_zero = (level == 23'd0);

    always_comb
    begin
        upd      = '0;
        upd.ent  = cur;
        unique case (req.func)
            FN_LOAD:
            begin
                upd.wr           = 1'b1;
                upd.ent.flags    = req.flags;
                upd.ent.header   = req.header;
                upd.ent.bank     = req.bank;
                upd.ent.volume   = req.volume;
                upd.ent.reported = req.last_level;
            end
            FN_FADE:
            begin
                upd.hit        = fade_hit;
                upd.wr         = fade_hit;
                upd.ent.flags  = cur.flags | FADE_FLAGS;
                upd.ent.step   = fade_step;
                upd.has1       = fade_hit;
                upd.res1.found = fade_hit;
                upd.res1.last  = 1'b1;
            end
            FN_STOP:
            begin
                upd.wr        = stop_hit;
                upd.ent.flags = 8'h00;
            end
            FN_TICK:
            begin
                upd.wr         = cur.flags[7] && running;
                upd.ent.volume = tick_vol;
            end
            FN_POLL:
            begin
                upd.wr           = lvl_new;
                upd.ent.reported = level;
                if (lvl_zero)
                begin
                    upd.ent.flags = 8'h00;
                end
                else if (level == LEVEL_MASK)
                begin
                    upd.ent.flags = cur.flags & ~FADE_FLAGS;
                end
                if (loc || ext)
                begin
                    upd.has1             = lvl_new;
                    upd.has2             = lvl_new && lvl_zero;
                    upd.res1.event_valid = 1'b1;
                    upd.res1.event_word  = LEVEL_EVENT | {17'd0, level[22:8]}
                                           | {24'd0, cur.bank};
                    upd.res1.to_local    = loc;
                    upd.res1.to_external = ext;
                    upd.res1.stop_group  = lvl_zero;
                    upd.res1.last        = !lvl_zero;
                    upd.res2.event_valid = 1'b1;
                    upd.res2.event_word  = STOP_EVENT | {24'd0, cur.bank};
                    upd.res2.to_local    = loc;
                    upd.res2.to_external = ext;
                    upd.res2.stop_group  = 1'b1;
                    upd.res2.last        = 1'b1;
                end
                else
                begin
                    upd.has1            = lvl_new && lvl_zero;
                    upd.res1.stop_group = 1'b1;
                    upd.res1.last       = 1'b1;
                end
            end
            default:
            begin
                upd.wr = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/track_volume_fade_engine.sv @@
// ============================================================================
// track_volume_fade_engine
// Track table with fade ramps, bank stop and level polling on one RAM.
// ============================================================================
//
//  channel   handshake            payload
//  --------  -------------------  -------------------------------------------
//  request   start & !busy        func track bank rate flags header volume
//                                 last_level
//  result    strobe (one cycle)   event_valid event_word to_local to_external
//                                 stop_group found last
//
// Sequence: load, tick and poll read the entry, then modify and write it
// back; a poll result shows on the cycle after, a second poll result in the
// cycle after that. Fade and stop sweep the table one entry a cycle through
// the RAM read port; a fade ends at its first match. Reset clears the
// per-entry valid bits at once, no clearing pass.
// Results cannot be stalled: each one holds for exactly one strobe cycle.
//
module track_volume_fade_engine import tvf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [3:0]  track,
    input  logic [7:0]  bank,
    input  logic [6:0]  rate,
    input  logic [7:0]  flags,
    input  logic [7:0]  header,
    input  logic [22:0] volume,
    input  logic [22:0] last_level,
    output logic        strobe,
    output logic        event_valid,
    output logic [31:0] event_word,
    output logic        to_local,
    output logic        to_external,
    output logic        stop_group,
    output logic        found,
    output logic        last
);

    state_t               state_reg, state_next;
    req_t                 req_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_TRACKS-1:0] valid_reg;
    logic                 rd_vld_reg;
    logic                 strobe_reg;
    res_t                 res_reg, res_next;
    res_t                 res2_reg;

    logic                 accept;
    logic [6:0]           track_ext;
    logic                 trk_ok;
    logic                 go_exec;
    logic                 go_scan;
    logic                 scan_last;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic                 res_load;
    logic                 res2_load;
    logic [ENTRY_W-1:0]   ram_q;
    entry_t               cur;
    upd_t                 upd;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign track_ext = {3'b000, track};
    assign trk_ok    = track_ext < 7'(NUM_TRACKS);
    assign go_exec   = trk_ok && ((func == FN_LOAD) || (func == FN_TICK) || (func == FN_POLL));
    // a stop of a bank with bit7 set does nothing: drop it at the door
    assign go_scan   = (func == FN_FADE) || ((func == FN_STOP) && !bank[7]);
    assign scan_last = (idx_reg == IDX_W'(NUM_TRACKS - 1));

    // entries never written read as the reset value
    assign cur = rd_vld_reg ? entry_t'(ram_q) : '0;

    tvf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TRACKS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_reg),
        .wdata (upd.ent),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    tvf_update u_update (
        .req (req_reg),
        .cur (cur),
        .upd (upd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && go_scan)
                begin
                    state_next = ST_SCAN;
                end
                else if (accept && go_exec)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                if (scan_last || ((req_reg.func == FN_FADE) && upd.hit))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                state_next = upd.has2 ? ST_EMIT2 : ST_IDLE;
            end
            ST_EMIT2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: read port, write port and result loads
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        wr_en     = 1'b0;
        idx_next  = idx_reg;
        res_load  = 1'b0;
        res2_load = 1'b0;
        res_next  = upd.res1;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en    = accept && (go_scan || go_exec);
                rd_addr  = go_scan ? '0 : track_ext[IDX_W-1:0];
                idx_next = rd_addr;
            end
            ST_SCAN:
            begin
                // read the next entry while this one is written back
                rd_en    = !scan_last;
                rd_addr  = IDX_W'(idx_reg + 1'b1);
                idx_next = rd_addr;
                wr_en    = upd.wr;
                res_load = (req_reg.func == FN_FADE) && (upd.hit || scan_last);
            end
            ST_EXEC:
            begin
                wr_en     = upd.wr;
                res_load  = upd.has1;
                res2_load = upd.has2;
            end
            ST_EMIT2:
            begin
                res_load = 1'b1;
                res_next = res2_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= res_load;
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // payload: hold the request and the results, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.func       <= func;
            req_reg.bank       <= bank;
            req_reg.rate       <= rate;
            req_reg.flags      <= flags;
            req_reg.header     <= header;
            req_reg.volume     <= volume;
            req_reg.last_level <= last_level;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (res2_load)
        begin
            res2_reg <= upd.res2;
        end
    end

    assign strobe      = strobe_reg;
    assign event_valid = res_reg.event_valid;
    assign event_word  = res_reg.event_word;
    assign to_local    = res_reg.to_local;
    assign to_external = res_reg.to_external;
    assign stop_group  = res_reg.stop_group;
    assign found       = res_reg.found;
    assign last        = res_reg.last;

endmodule
